/* rtl/core/hhl_pkg.sv */
// shared types, codes and character classes for the http header lexer
package hhl_pkg;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_FINAL_LF   = 3'd1,
        PH_NAME       = 3'd2,
        PH_VALUE      = 3'd3,
        PH_VALUE_LF   = 3'd4,
        PH_AFTER_LF   = 3'd5,
        PH_DONE       = 3'd6,
        PH_FAILED     = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_NAME   = 3'd1,
        K_VALUE  = 3'd2,
        K_HDREND = 3'd3,
        K_BLKEND = 3'd4,
        K_ERROR  = 3'd5,
        K_IGNORE = 3'd6
    } t_kind;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CTL_MAX = 8'h1f;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // lexer state carried from item to item
    typedef struct packed {
        t_phase phase;
        logic   pending_space;
        logic   value_empty;
    } t_state;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        logic       last;
    } t_result;

    // control characters
    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_CTL_MAX) || (c == CH_DEL);
    endfunction

    // separator characters of the token grammar
    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c,
            8'h3b, 8'h3a, 8'h5c, 8'h22, 8'h2f, 8'h5b,
            8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20,
            8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // token characters: printable ascii that is not a separator
    function automatic logic is_tok(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;
    endfunction

endpackage

/* rtl/core/hhl_if.sv */
// valid/ready channel interfaces for header bytes and lexer results
interface hhl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface hhl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output kind, output char_out, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

/* rtl/core/hhl_step.sv */
// next-state and result logic for one header byte
module hhl_step
    import hhl_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_state     o_state,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic       o_two
);

    logic       ws;
    t_phase     lf_phase;
    t_kind      lf_kind;
    logic [7:0] lf_char;
    t_kind      k0;
    logic [7:0] c0;
    t_kind      k1;
    logic [7:0] c1;

    assign ws = (i_byte == CH_SPACE) || (i_byte == CH_TAB);

    // first byte of a line: empty-line cr, name start or error
    always_comb begin
        if (i_byte == CH_CR) begin
            lf_phase = PH_FINAL_LF;
            lf_kind  = K_NONE;
            lf_char  = 8'd0;
        end else if (is_tok(i_byte)) begin
            lf_phase = PH_NAME;
            lf_kind  = K_NAME;
            lf_char  = to_lower(i_byte);
        end else begin
            lf_phase = PH_FAILED;
            lf_kind  = K_ERROR;
            lf_char  = 8'd0;
        end
    end

    // phase decode
    always_comb begin
        o_state = i_state;
        o_two   = 1'b0;
        k0      = K_NONE;
        c0      = 8'd0;
        k1      = K_NONE;
        c1      = 8'd0;
        case (i_state.phase)
            PH_DONE, PH_FAILED: begin
                k0 = K_IGNORE;
            end
            PH_LINE_START: begin
                if (i_end) begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end else begin
                    o_state.phase = lf_phase;
                    k0 = lf_kind;
                    c0 = lf_char;
                end
            end
            PH_FINAL_LF: begin
                if (!i_end && (i_byte == CH_LF)) begin
                    o_state.phase = PH_DONE;
                    k0 = K_BLKEND;
                end else begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end
            end
            PH_NAME: begin
                if (!i_end && (i_byte == CH_COLON)) begin
                    o_state.phase         = PH_VALUE;
                    o_state.pending_space = 1'b0;
                    o_state.value_empty   = 1'b1;
                end else if (!i_end && is_tok(i_byte)) begin
                    k0 = K_NAME;
                    c0 = to_lower(i_byte);
                end else begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end
            end
            PH_VALUE: begin
                if (i_end) begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end else if (i_byte == CH_CR) begin
                    o_state.phase = PH_VALUE_LF;
                end else if (ws) begin
                    o_state.pending_space = !i_state.value_empty;
                end else if (!is_ctl(i_byte)) begin
                    // a held space goes out ahead of the value char
                    if (i_state.pending_space) begin
                        o_two = 1'b1;
                        k0 = K_VALUE;
                        c0 = CH_SPACE;
                        k1 = K_VALUE;
                        c1 = i_byte;
                    end else begin
                        k0 = K_VALUE;
                        c0 = i_byte;
                    end
                    o_state.pending_space = 1'b0;
                    o_state.value_empty   = 1'b0;
                end else begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end
            end
            PH_VALUE_LF: begin
                if (!i_end && (i_byte == CH_LF)) begin
                    o_state.phase = PH_AFTER_LF;
                end else begin
                    o_state.phase = PH_FAILED;
                    k0 = K_ERROR;
                end
            end
            default: begin
                // after a value crlf: fold or end the header
                if (!i_end && ws) begin
                    o_state.phase         = PH_VALUE;
                    o_state.pending_space = !i_state.value_empty;
                end else begin
                    o_two = 1'b1;
                    k0 = K_HDREND;
                    if (i_end) begin
                        o_state.phase = PH_FAILED;
                        k1 = K_ERROR;
                    end else begin
                        o_state.phase = lf_phase;
                        k1 = lf_kind;
                        c1 = lf_char;
                    end
                end
            end
        endcase
    end

    assign o_res0 = '{kind: k0, char_out: c0, last: !o_two};
    assign o_res1 = '{kind: k1, char_out: c1, last: 1'b1};

endmodule

/* rtl/core/http_header_lexer.sv */
// a taken byte is held in the byte register, its decoded results in the result slots;
// throughput: one byte per cycle while results are taken; a byte with two results
// holds the input stage until its first result is taken; byte register and two-slot
// result register part the sides; a waiting result stalls only a full byte register
// reset: synchronous active-low i_rst_n clears both stages and returns to line start
// top level of the http header lexer
module http_header_lexer
    import hhl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hhl_in_if.sink    i_in,
    hhl_out_if.source o_out
);

    t_state     r_state;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic [1:0] r_cnt;
    t_result    r_slot0;
    t_result    r_slot1;

    t_state     n_state;
    t_result    n_res0;
    t_result    n_res1;
    logic       n_two;
    logic       proc;
    logic       out_xfer;
    logic       in_xfer;

    // byte decode
    hhl_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_state (n_state),
        .o_res0  (n_res0),
        .o_res1  (n_res1),
        .o_two   (n_two)
    );

    // handshakes
    assign out_xfer = o_out.valid && o_out.ready;
    assign proc     = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready));
    assign i_in.ready = !r_in_valid || proc;
    assign in_xfer  = i_in.valid && i_in.ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '{phase: PH_LINE_START, pending_space: 1'b0, value_empty: 1'b1};
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (proc) begin
                r_state <= n_state;
                r_cnt   <= n_two ? 2'd2 : 2'd1;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.stream_end;
        end
        if (proc) begin
            r_slot0 <= n_res0;
            r_slot1 <= n_res1;
        end else if (out_xfer) begin
            r_slot0 <= r_slot1;
        end
    end

    // result port
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.kind     = r_slot0.kind;
    assign o_out.char_out = r_slot0.char_out;
    assign o_out.last     = r_slot0.last;

endmodule

/* rtl/core/hhl_checker.sv */
// port-level checks on the http header lexer, bound to the top level
module hhl_checker
    import hhl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    logic r_final;
    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    // remember a block end or error seen on the result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final <= 1'b0;
        end else if (out_xfer && ((i_out_kind == K_BLKEND) || (i_out_kind == K_ERROR))) begin
            r_final <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_char) && $stable(i_out_last))
        else $error("result changed while stalled");

    // only name and value results carry a character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != K_NAME) && (i_out_kind != K_VALUE) |-> i_out_char == 8'd0)
        else $error("character on a non-character result");

    // a header end is always followed by a result of the same byte
    a_hdrend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == K_HDREND) |-> !i_out_last)
        else $error("header end marked last");

    // name characters come out lowercased
    a_name_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == K_NAME) |-> (i_out_char < CH_UP_A) || (i_out_char > CH_UP_Z))
        else $error("uppercase name character");

    // after block end or error only ignored results follow
    a_sticky_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final && i_out_valid |-> i_out_kind == K_IGNORE)
        else $error("result after block end or error not ignored");

endmodule

bind http_header_lexer hhl_checker u_hhl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.last)
);
